### design/mfuw_pkg.sv
// Package: shared types, constants and action codes for the motor feedback unwrap block.
`default_nettype none

package mfuw_pkg;

  localparam int MOTOR_COUNT_DEF = 8;
  localparam int IDX_W           = 3;
  localparam int ANGLE_W         = 13;
  localparam int TOTAL_W         = 32;
  localparam int SAMPLE_W        = 16;
  localparam int COUNT_W         = 8;
  localparam int HALF_TURN       = 4095;
  localparam int TURN_STEP       = 8191;
  localparam int LIMIT_RESET     = 50;

  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // One motor's feedback record as held in the state memory.
  typedef struct packed {
    logic                       seen;
    logic [ANGLE_W-1:0]         prev_angle;
    logic [TOTAL_W-1:0]         total;
    logic [COUNT_W-1:0]         silence;
    logic                       online;
    logic signed [SAMPLE_W-1:0] speed;
    logic signed [SAMPLE_W-1:0] current;
  } mfuw_rec_t;

  localparam mfuw_rec_t REC_RESET = '{
    seen:       1'b0,
    prev_angle: '0,
    total:      '0,
    silence:    COUNT_W'(LIMIT_RESET + 1),
    online:     1'b0,
    speed:      '0,
    current:    '0
  };

endpackage

`default_nettype wire

### design/mfuw_update.sv
// Record update: applies one frame, tick or clear transaction to a motor record.
`default_nettype none

module mfuw_update (
  input  mfuw_pkg::mfuw_rec_t                 rec,
  input  logic [1:0]                          action,
  input  logic [mfuw_pkg::ANGLE_W-1:0]        raw_angle,
  input  logic signed [mfuw_pkg::SAMPLE_W-1:0] speed_in,
  input  logic signed [mfuw_pkg::SAMPLE_W-1:0] current_in,
  input  logic [mfuw_pkg::COUNT_W-1:0]        limit,
  output mfuw_pkg::mfuw_rec_t                 rec_next
);
  import mfuw_pkg::*;

  logic [ANGLE_W-1:0]    prev;
  logic signed [ANGLE_W:0] diff;
  logic signed [ANGLE_W:0] delta;
  logic [COUNT_W:0]      cnt;
  logic [COUNT_W:0]      ceil_cnt;
  logic [COUNT_W:0]      sat_cnt;

  // Unwrap: seed on first frame, fold steps larger than half a turn.
  always_comb begin
    prev = rec.seen ? rec.prev_angle : raw_angle;
    diff = $signed({1'b0, raw_angle}) - $signed({1'b0, prev});
    if (diff > $signed((ANGLE_W+1)'(HALF_TURN))) begin
      delta = diff - $signed((ANGLE_W+1)'(TURN_STEP));
    end else if (diff < -$signed((ANGLE_W+1)'(HALF_TURN))) begin
      delta = diff + $signed((ANGLE_W+1)'(TURN_STEP));
    end else begin
      delta = diff;
    end
  end

  // Silence counter saturates at limit + 1, held to the counter width.
  always_comb begin
    cnt      = {1'b0, rec.silence} + (COUNT_W+1)'(1);
    ceil_cnt = (limit == {COUNT_W{1'b1}}) ? {1'b0, limit} : ({1'b0, limit} + (COUNT_W+1)'(1));
    sat_cnt  = (cnt > ceil_cnt) ? ceil_cnt : cnt;
  end

  always_comb begin
    rec_next = rec;
    case (action_t'(action))
      ACT_FRAME: begin
        rec_next.seen       = 1'b1;
        rec_next.prev_angle = raw_angle;
        rec_next.total      = rec.total + {{(TOTAL_W-ANGLE_W-1){delta[ANGLE_W]}}, delta};
        rec_next.silence    = '0;
        rec_next.speed      = speed_in;
        rec_next.current    = current_in;
      end
      ACT_TICK: begin
        rec_next.silence = sat_cnt[COUNT_W-1:0];
        rec_next.online  = (sat_cnt <= {1'b0, limit});
      end
      ACT_CLEAR: begin
        rec_next.total = '0;
      end
      default: begin
        rec_next = rec;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/motor_feedback_unwrap_watchdog_core.sv
// Top level: per-motor feedback store with multi-turn angle unwrap and silence watchdog.
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_stall   action, motor_index, raw_angle, speed_in, current_in
// out       source     out_valid / out_stall motor_out, angle_total, angle_now, speed_now,
//                                            current_now, online
// cfg       sink       cfg_valid / cfg_ready cfg_data (offline_limit)
//
// One transaction per cycle sustained while the output is not stalled; each accepted
// transaction is registered into the update stage and its result into the output
// register. The motor records sit in one memory read in the accept cycle and written back
// from the update stage; the last write is kept and forwarded when the next transaction
// hits the same motor. Never-written records read as their reset view through per-motor
// valid bits, so reset needs no clearing pass. A stalled output holds the update stage,
// which in turn stalls the input.

module motor_feedback_unwrap_watchdog_core #(
  parameter int MOTOR_COUNT = mfuw_pkg::MOTOR_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           action,
  input  logic [mfuw_pkg::IDX_W-1:0]           motor_index,
  input  logic [mfuw_pkg::ANGLE_W-1:0]         raw_angle,
  input  logic signed [mfuw_pkg::SAMPLE_W-1:0] speed_in,
  input  logic signed [mfuw_pkg::SAMPLE_W-1:0] current_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mfuw_pkg::IDX_W-1:0]           motor_out,
  output logic signed [mfuw_pkg::TOTAL_W-1:0]  angle_total,
  output logic [mfuw_pkg::ANGLE_W-1:0]         angle_now,
  output logic signed [mfuw_pkg::SAMPLE_W-1:0] speed_now,
  output logic signed [mfuw_pkg::SAMPLE_W-1:0] current_now,
  output logic                                 online,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mfuw_pkg::COUNT_W-1:0]         cfg_data
);
  import mfuw_pkg::*;

  localparam int AW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;

  // Configuration register.
  logic [COUNT_W-1:0] offline_limit;

  // Record memory and per-motor written marks.
  mfuw_rec_t        mem [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] written;

  // Accept stage.
  logic          in_fire;
  logic [XW-1:0] idx_x;
  logic [AW-1:0] in_addr;
  logic          in_range;

  // Update stage.
  logic                       s1_valid;
  logic                       s1_range;
  logic [AW-1:0]              s1_addr;
  logic [IDX_W-1:0]           s1_index;
  logic [1:0]                 s1_action;
  logic [ANGLE_W-1:0]         s1_angle;
  logic signed [SAMPLE_W-1:0] s1_speed;
  logic signed [SAMPLE_W-1:0] s1_current;
  mfuw_rec_t                  rd_rec;
  logic                       rd_written;
  mfuw_rec_t                  cur_rec;
  mfuw_rec_t                  new_rec;
  logic                       s1_fire;
  logic                       out_free;

  // Last write-back, kept for forwarding.
  logic          wb_live;
  logic [AW-1:0] wb_addr;
  mfuw_rec_t     wb_rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offline_limit <= COUNT_W'(LIMIT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      offline_limit <= cfg_data;
    end
  end

  // Drop indexes past the last motor: no read, no write, zero view.
  always_comb begin
    idx_x    = XW'(motor_index);
    in_addr  = idx_x[AW-1:0];
    in_range = ({{(32-IDX_W){1'b0}}, motor_index} < 32'(MOTOR_COUNT));
  end

  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_fire  = in_valid && !in_stall;

  // Memory read, issued on accept.
  always_ff @(posedge clk) begin
    if (in_fire && in_range) begin
      rd_rec     <= mem[in_addr];
      rd_written <= written[in_addr];
    end
  end

  // Memory write-back from the update stage.
  always_ff @(posedge clk) begin
    if (s1_fire && s1_range) begin
      mem[s1_addr] <= new_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      wb_live <= 1'b0;
    end else if (s1_fire && s1_range) begin
      written[s1_addr] <= 1'b1;
      wb_live          <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_range) begin
      wb_addr <= s1_addr;
      wb_rec  <= new_rec;
    end
  end

  // Update stage payload: advance on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_range   <= in_range;
      s1_addr    <= in_addr;
      s1_index   <= motor_index;
      s1_action  <= action;
      s1_angle   <= raw_angle;
      s1_speed   <= speed_in;
      s1_current <= current_in;
    end
  end

  // Forward the most recent write when it hit the same motor; the memory read may
  // have raced it. A never-written record reads as its reset view.
  always_comb begin
    if (wb_live && (wb_addr == s1_addr)) begin
      cur_rec = wb_rec;
    end else if (rd_written) begin
      cur_rec = rd_rec;
    end else begin
      cur_rec = REC_RESET;
    end
  end

  mfuw_update u_update (
    .rec        (cur_rec),
    .action     (s1_action),
    .raw_angle  (s1_angle),
    .speed_in   (s1_speed),
    .current_in (s1_current),
    .limit      (offline_limit),
    .rec_next   (new_rec)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      motor_out <= s1_index;
      if (s1_range) begin
        angle_total <= new_rec.total;
        angle_now   <= new_rec.prev_angle;
        speed_now   <= new_rec.speed;
        current_now <= new_rec.current;
        online      <= new_rec.online;
      end else begin
        angle_total <= '0;
        angle_now   <= '0;
        speed_now   <= '0;
        current_now <= '0;
        online      <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### verif/motor_feedback_unwrap_watchdog_checker.sv
`timescale 1ns / 100ps
// Checker: tracks every motor record from the accepted transactions and compares each result view.
module motor_feedback_unwrap_watchdog_checker #(
  parameter int MOTOR_COUNT = mfuw_pkg::MOTOR_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [1:0]                           action,
  input  logic [mfuw_pkg::IDX_W-1:0]           motor_index,
  input  logic [mfuw_pkg::ANGLE_W-1:0]         raw_angle,
  input  logic signed [mfuw_pkg::SAMPLE_W-1:0] speed_in,
  input  logic signed [mfuw_pkg::SAMPLE_W-1:0] current_in,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [mfuw_pkg::IDX_W-1:0]           motor_out,
  input  logic signed [mfuw_pkg::TOTAL_W-1:0]  angle_total,
  input  logic [mfuw_pkg::ANGLE_W-1:0]         angle_now,
  input  logic signed [mfuw_pkg::SAMPLE_W-1:0] speed_now,
  input  logic signed [mfuw_pkg::SAMPLE_W-1:0] current_now,
  input  logic                                 online,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [mfuw_pkg::COUNT_W-1:0]         cfg_data,
  output int                                   mismatch_count,
  output int                                   pending_views
);
  import mfuw_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]           motor;
    logic signed [TOTAL_W-1:0]  total;
    logic [ANGLE_W-1:0]         angle;
    logic signed [SAMPLE_W-1:0] speed;
    logic signed [SAMPLE_W-1:0] current;
    logic                       online;
  } motor_view_t;

  motor_view_t view_queue[$];

  logic                       seen_q    [MOTOR_COUNT];
  logic [ANGLE_W-1:0]         prev_q    [MOTOR_COUNT];
  logic [TOTAL_W-1:0]         total_q   [MOTOR_COUNT];
  logic [COUNT_W-1:0]         silence_q [MOTOR_COUNT];
  logic                       online_q  [MOTOR_COUNT];
  logic signed [SAMPLE_W-1:0] speed_q   [MOTOR_COUNT];
  logic signed [SAMPLE_W-1:0] current_q [MOTOR_COUNT];
  logic [COUNT_W-1:0]         limit_q;

  // Saturate the silence counter one above the limit, but never past its width.
  function automatic int silence_ceiling();
    return (int'(limit_q) + 1 > 255) ? 255 : int'(limit_q) + 1;
  endfunction

  task automatic report_mismatch(string msg);
    $display("checker: %s at %0t", msg, $time);
    mismatch_count++;
  endtask

  task automatic check_field(int motor, string name, logic signed [63:0] got_v,
                             logic signed [63:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("motor %0d %s: got %0d expected %0d",
                                motor, name, got_v, want_v));
  endtask

  task automatic clear_records();
    limit_q = COUNT_W'(LIMIT_RESET);
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      seen_q[m]    = 1'b0;
      prev_q[m]    = '0;
      total_q[m]   = '0;
      silence_q[m] = COUNT_W'(silence_ceiling());
      online_q[m]  = 1'b0;
      speed_q[m]   = '0;
      current_q[m] = '0;
    end
    view_queue.delete();
  endtask

  // Apply one transaction to the motor record and build the view it returns.
  task automatic advance_motor(input action_t act, input int m, input logic [ANGLE_W-1:0] ang,
                               input logic signed [SAMPLE_W-1:0] spd,
                               input logic signed [SAMPLE_W-1:0] cur,
                               output motor_view_t view);
    int delta;
    int ticks;
    view = '0;
    view.motor = IDX_W'(m);
    if (m >= MOTOR_COUNT) return;
    case (act)
      ACT_FRAME: begin
        speed_q[m]   = spd;
        current_q[m] = cur;
        silence_q[m] = '0;
        if (!seen_q[m]) begin
          seen_q[m] = 1'b1;
          prev_q[m] = ang;
        end
        delta = int'(ang) - int'(prev_q[m]);
        if (delta > HALF_TURN) delta -= TURN_STEP;
        else if (delta < -HALF_TURN) delta += TURN_STEP;
        total_q[m] = total_q[m] + TOTAL_W'(delta);
        prev_q[m]  = ang;
      end
      ACT_TICK: begin
        ticks = int'(silence_q[m]) + 1;
        if (ticks > silence_ceiling()) ticks = silence_ceiling();
        silence_q[m] = COUNT_W'(ticks);
        online_q[m]  = (ticks <= int'(limit_q));
      end
      ACT_CLEAR: total_q[m] = '0;
      default: ;
    endcase
    view.total   = total_q[m];
    view.angle   = prev_q[m];
    view.speed   = speed_q[m];
    view.current = current_q[m];
    view.online  = online_q[m];
  endtask

  always @(posedge clk) begin : watch
    motor_view_t want;
    motor_view_t next_view;
    if (rst) begin
      clear_records();
    end else begin
      // Compare first: a result never belongs to a transaction accepted at this edge.
      if (out_valid && !out_stall) begin
        if (view_queue.size() == 0) begin
          report_mismatch($sformatf("result for motor %0d with nothing pending", motor_out));
        end else begin
          want = view_queue.pop_front();
          check_field(want.motor, "motor_out", motor_out, want.motor);
          check_field(want.motor, "angle_total", angle_total, want.total);
          check_field(want.motor, "angle_now", angle_now, want.angle);
          check_field(want.motor, "speed_now", speed_now, want.speed);
          check_field(want.motor, "current_now", current_now, want.current);
          check_field(want.motor, "online", online, want.online);
        end
      end
      if (in_valid && !in_stall) begin
        advance_motor(action_t'(action), int'(motor_index), raw_angle, speed_in, current_in,
                      next_view);
        view_queue.push_back(next_view);
      end
      if (cfg_valid && cfg_ready) limit_q = cfg_data;
    end
    pending_views = view_queue.size();
  end

endmodule

### verif/motor_feedback_unwrap_watchdog_core_test.sv
`timescale 1ns / 100ps
// Testbench top: drives feedback, tick and clear transactions into the core and gives the verdict.
module motor_feedback_unwrap_watchdog_core_test;
  import mfuw_pkg::*;

  localparam int STALL_LIMIT     = 2000;  // cycles with no handshake before giving up
  localparam int ITEMS_PER_PHASE = 225;
  localparam int DIRECTED_ITEMS  = 21;
  localparam int SETTLE_CYCLES   = 4;     // two-stage pipeline plus write-back margin
  localparam int DRAIN_CYCLES    = 8;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [1:0]                 action;
  logic [IDX_W-1:0]           motor_index;
  logic [ANGLE_W-1:0]         raw_angle;
  logic signed [SAMPLE_W-1:0] speed_in;
  logic signed [SAMPLE_W-1:0] current_in;
  logic                       out_valid;
  logic                       out_stall;
  logic [IDX_W-1:0]           motor_out;
  logic signed [TOTAL_W-1:0]  angle_total;
  logic [ANGLE_W-1:0]         angle_now;
  logic signed [SAMPLE_W-1:0] speed_now;
  logic signed [SAMPLE_W-1:0] current_now;
  logic                       online;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [COUNT_W-1:0]         cfg_data;

  int mismatch_count;
  int pending_views;
  int idle_cycles;
  int n_frame, n_tick, n_clear, n_unused, n_cfg, n_drain;

  // Quiet mode turns off idling on both sides so that transactions run back to back.
  bit quiet;

  // Last angle sent per motor, used only to shape rotation-like frame sequences.
  logic [ANGLE_W-1:0] stim_angle [MOTOR_COUNT_DEF];

  motor_feedback_unwrap_watchdog_core uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .motor_index (motor_index),
    .raw_angle   (raw_angle),
    .speed_in    (speed_in),
    .current_in  (current_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .motor_out   (motor_out),
    .angle_total (angle_total),
    .angle_now   (angle_now),
    .speed_now   (speed_now),
    .current_now (current_now),
    .online      (online),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  motor_feedback_unwrap_watchdog_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .motor_index    (motor_index),
    .raw_angle      (raw_angle),
    .speed_in       (speed_in),
    .current_in     (current_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .motor_out      (motor_out),
    .angle_total    (angle_total),
    .angle_now      (angle_now),
    .speed_now      (speed_now),
    .current_now    (current_now),
    .online         (online),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_views  (pending_views)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random speed or current sample.
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    return SAMPLE_W'($urandom);
  endfunction

  // Next frame angle: small steps, steps at the half-turn edge, random jumps, end values or a repeat.
  function automatic logic [ANGLE_W-1:0] pick_angle(logic [ANGLE_W-1:0] prior);
    int k;
    int delta;
    k = $urandom_range(0, 9);
    if (k >= 6 && k <= 7) return ANGLE_W'($urandom);
    if (k == 8) return $urandom_range(0, 1) ? '1 : '0;
    if (k == 9) return prior;
    if (k == 5) delta = HALF_TURN + $urandom_range(0, 3) - 1;
    else delta = $urandom_range(0, 300);
    if ($urandom_range(0, 1)) delta = -delta;
    return ANGLE_W'(int'(prior) + delta);
  endfunction

  // Present one transaction, hold it until accepted, then idle the sender at random.
  task automatic send_item(action_t act, int m, logic [ANGLE_W-1:0] ang,
                           logic [SAMPLE_W-1:0] spd, logic [SAMPLE_W-1:0] cur);
    int gap;
    action      <= act;
    motor_index <= IDX_W'(m);
    raw_angle   <= ang;
    speed_in    <= spd;
    current_in  <= cur;
    in_valid    <= 1'b1;
    case (act)
      ACT_FRAME: begin
        n_frame++;
        stim_angle[m] = ang;
      end
      ACT_TICK:  n_tick++;
      ACT_CLEAR: n_clear++;
      default:   n_unused++;
    endcase
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    gap = quiet ? 0 : gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold the sender off until every pending view has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_views != 0) @(negedge clk);
    n_drain++;
  endtask

  // Write the offline limit only once the pipeline is empty and settled.
  task automatic write_limit(int value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= COUNT_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  // Random traffic: tick bursts, some long enough to cross the limit, rotation sequences
  // that may wrap the encoder, single transactions, and some fully random noise.
  task automatic run_phase(int n_items, int lim);
    int done;
    int r;
    int m;
    int len;
    int step;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 39) == 0) quiet = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 149) == 0) wait_drained();
      r = $urandom_range(0, 99);
      m = $urandom_range(0, MOTOR_COUNT_DEF - 1);
      if (r < 10) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, lim + 3) : $urandom_range(1, 6);
        repeat (len) send_item(ACT_TICK, m, ANGLE_W'($urandom), rand_sample(), rand_sample());
        done += len;
      end else if (r < 20) begin
        step = $urandom_range(1, 600);
        if ($urandom_range(0, 1)) step = -step;
        len = $urandom_range(4, 16);
        repeat (len)
          send_item(ACT_FRAME, m, ANGLE_W'(int'(stim_angle[m]) + step), rand_sample(),
                    rand_sample());
        done += len;
      end else begin
        if (r < 60)
          send_item(ACT_FRAME, m, pick_angle(stim_angle[m]), rand_sample(), rand_sample());
        else if (r < 85)
          send_item(ACT_TICK, m, ANGLE_W'($urandom), rand_sample(), rand_sample());
        else if (r < 93)
          send_item(ACT_CLEAR, m, ANGLE_W'($urandom), rand_sample(), rand_sample());
        else
          send_item(action_t'($urandom_range(0, 3)), m, ANGLE_W'($urandom), rand_sample(),
                    rand_sample());
        done++;
      end
    end
  endtask

  // Receiver side: stall in bursts of random length, never while quiet.
  initial begin : receiver
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = quiet ? 0 : gap_length();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // Abort when no channel completes a transaction for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int limit_plan [7];
    rst         = 1'b1;
    in_valid    = 1'b0;
    action      = ACT_FRAME;
    motor_index = '0;
    raw_angle   = '0;
    speed_in    = '0;
    current_in  = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    idle_cycles = 0;
    quiet       = 1'b1;
    foreach (stim_angle[i]) stim_angle[i] = '0;
    limit_plan = '{0, 3, 255, 254, 1, 0, LIMIT_RESET};
    limit_plan[5] = $urandom_range(2, 253);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, back to back so that same-motor forwarding is hit.
    // Tick and unused code before any frame: the motor stays offline at reset.
    send_item(ACT_TICK, 0, '0, '0, '0);
    send_item(ACT_NONE, 5, '1, 16'h7fff, 16'h8000);
    // First frame seeds the previous angle, so the total stays zero.
    send_item(ACT_FRAME, 0, 13'd8191, 16'h8000, 16'h7fff);
    // Full-turn and half-turn steps in both directions around the 4095 threshold.
    send_item(ACT_FRAME, 0, 13'd0, 16'h0001, 16'hffff);
    send_item(ACT_FRAME, 0, 13'd4095, 16'h0000, 16'h0000);
    send_item(ACT_FRAME, 0, 13'd0, 16'hffff, 16'h0001);
    send_item(ACT_FRAME, 0, 13'd4096, 16'h5555, 16'haaaa);
    send_item(ACT_FRAME, 0, 13'd0, 16'haaaa, 16'h5555);
    send_item(ACT_FRAME, 0, 13'd8191, 16'h7fff, 16'h8000);
    send_item(ACT_FRAME, 0, 13'd4095, 16'h8000, 16'h7fff);
    send_item(ACT_FRAME, 1, 13'd0, 16'h7fff, 16'h8000);
    send_item(ACT_FRAME, 1, 13'd4097, 16'h1234, 16'hedcb);
    // A tick after a frame brings the motor online.
    send_item(ACT_TICK, 0, '1, '1, '1);
    send_item(ACT_TICK, 1, '0, '0, '0);
    send_item(ACT_CLEAR, 0, '1, '1, '1);
    send_item(ACT_TICK, 0, '0, '0, '0);
    // Clear on a motor never seen, then its seeding frame.
    send_item(ACT_CLEAR, 3, '0, '0, '0);
    send_item(ACT_FRAME, 3, 13'd1, 16'h0001, 16'h0001);
    send_item(ACT_NONE, 1, '0, '0, '0);
    send_item(ACT_FRAME, 7, 13'd4096, 16'h0000, 16'hffff);
    send_item(ACT_TICK, 7, '0, '0, '0);
    wait_drained();

    quiet = 1'b0;
    run_phase(ITEMS_PER_PHASE - DIRECTED_ITEMS, LIMIT_RESET);
    // Counters carry over between settings, so each new limit also re-saturates them.
    foreach (limit_plan[i]) begin
      write_limit(limit_plan[i]);
      run_phase(ITEMS_PER_PHASE, limit_plan[i]);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("summary: %0d frames, %0d ticks, %0d clears, %0d unused-code transactions",
             n_frame, n_tick, n_clear, n_unused);
    $display("summary: %0d limit writes incl. 0, 254 and 255, %0d drain pauses",
             n_cfg, n_drain);
    if (mismatch_count == 0 && pending_views == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### motor_feedback_unwrap_watchdog_core.f
design/mfuw_pkg.sv
design/mfuw_update.sv
design/motor_feedback_unwrap_watchdog_core.sv
verif/motor_feedback_unwrap_watchdog_checker.sv
verif/motor_feedback_unwrap_watchdog_core_test.sv
